@@ design/stfcs_pkg.sv @@
// package for the sorted table floor/ceil search block
// op codes and result constants; no dependencies
package stfcs_pkg;

    // operation codes carried by the input word
    typedef logic [1:0] t_op;

    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    // table word and the value reported when no bound exists
    typedef logic signed [31:0] t_word;

    localparam t_word NOT_FOUND = -32'sd1;

endpackage

@@ design/stfcs_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module stfcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ design/sorted_table_floor_ceil_search.sv @@
// Sorted table floor/ceil search. Holds up to TABLE_DEPTH signed 32-bit words in
// one memory, assumed ascending (not checked). A clear word empties the table, an
// append word adds one entry at the end (dropped when full), and a query word runs
// one binary search whose probe sequence yields both the floor (largest entry not
// above the target) and the ceil (smallest entry not below it), each with a found
// flag and -1 when absent. Clear and append complete when accepted. A query walks
// ST_PROBE (table read) and ST_WAIT (compare) per probe, at most ceil(log2(n+1))
// probes for n entries, then a last ST_PROBE loads the result; the probe loop is
// paced by the table's registered read. One word is worked on at a time; the
// result sits in an output register until taken, while the next word is accepted.
// A query that ends while that register is still full waits for it to drain.
// depends on stfcs_pkg and stfcs_ram
module sorted_table_floor_ceil_search
    import stfcs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_floor_found,
    output logic signed [31:0] o_floor_value,
    output logic               o_ceil_found,
    output logic signed [31:0] o_ceil_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi1, n_hi1;   // one past the upper search bound
    logic [CW-1:0] r_mid, n_mid;
    t_word         r_target, n_target;
    logic          r_ff, n_ff;
    t_word         r_fv, n_fv;
    logic          r_cf, n_cf;
    t_word         r_cv, n_cv;
    logic          r_out_valid, n_out_valid;
    logic          r_o_ff, n_o_ff;
    t_word         r_o_fv, n_o_fv;
    logic          r_o_cf, n_o_cf;
    t_word         r_o_cv, n_o_cv;

    logic          in_acc;
    logic          wr_en;
    logic          rd_en;
    logic [CW-1:0] span;
    logic [CW-1:0] mid;
    logic [31:0]   rd_data;
    t_word         probe;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    // midpoint of [lo, hi1 - 1]
    assign span  = r_hi1 - r_lo - CW'(1);
    assign mid   = r_lo + (span >> 1);
    assign probe = $signed(rd_data);

    assign wr_en = in_acc && (i_op == OP_APPEND) && (r_count < CW'(TABLE_DEPTH));
    assign rd_en = (r_state == ST_PROBE) && (r_lo < r_hi1);

    // table storage
    stfcs_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (mid[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // next state and search datapath
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_target    = r_target;
        n_ff        = r_ff;
        n_fv        = r_fv;
        n_cf        = r_cf;
        n_cv        = r_cv;
        n_out_valid = r_out_valid;
        n_o_ff      = r_o_ff;
        n_o_fv      = r_o_fv;
        n_o_cf      = r_o_cf;
        n_o_cv      = r_o_cv;

        // output register drains
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (wr_en) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_lo     = '0;
                            n_hi1    = r_count;
                            n_target = i_value;
                            n_ff     = 1'b0;
                            n_fv     = NOT_FOUND;
                            n_cf     = 1'b0;
                            n_cv     = NOT_FOUND;
                            n_state  = ST_PROBE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi1) begin
                    n_mid   = mid;
                    n_state = ST_WAIT;
                end else if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_ff      = r_ff;
                    n_o_fv      = r_fv;
                    n_o_cf      = r_cf;
                    n_o_cv      = r_cv;
                    n_state     = ST_IDLE;
                end
            end
            ST_WAIT: begin
                n_state = ST_PROBE;
                if (probe == r_target) begin
                    // exact hit ends the search with both bounds equal to target
                    n_ff  = 1'b1;
                    n_fv  = probe;
                    n_cf  = 1'b1;
                    n_cv  = probe;
                    n_hi1 = r_lo;
                end else if (probe > r_target) begin
                    n_cf  = 1'b1;
                    n_cv  = probe;
                    n_hi1 = r_mid;
                end else begin
                    n_ff = 1'b1;
                    n_fv = probe;
                    n_lo = r_mid + CW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi1    <= n_hi1;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_ff     <= n_ff;
        r_fv     <= n_fv;
        r_cf     <= n_cf;
        r_cv     <= n_cv;
        r_o_ff   <= n_o_ff;
        r_o_fv   <= n_o_fv;
        r_o_cf   <= n_o_cf;
        r_o_cv   <= n_o_cv;
    end

    assign o_valid       = r_out_valid;
    assign o_floor_found = r_o_ff;
    assign o_floor_value = r_o_fv;
    assign o_ceil_found  = r_o_cf;
    assign o_ceil_value  = r_o_cv;

endmodule

@@ dv/sorted_table_floor_ceil_search_test.sv @@
// testbench for sorted_table_floor_ceil_search: directed, full-table, unsorted and random tests
// keeps its own copy of the table, predicts floor/ceil per query word; needs stfcs_pkg and the rtl
`timescale 1ns / 1ps

module sorted_table_floor_ceil_search_test;
    import stfcs_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 64;

    // op code the block leaves unused
    localparam t_op OP_UNUSED = 2'd3;

    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic  floor_found;
        t_word floor_value;
        logic  ceil_found;
        t_word ceil_value;
    } t_bounds;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        o_ready;
    t_op         i_op     = OP_CLEAR;
    t_word       i_value  = '0;
    logic        o_valid;
    logic        i_ready  = 1'b0;
    logic        o_floor_found;
    t_word       o_floor_value;
    logic        o_ceil_found;
    t_word       o_ceil_value;

    // mirror of the table contents and the expected bounds per query
    t_word       table_mirror [DEPTH];
    int          mirror_count = 0;
    t_bounds     expected_bounds [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          error_count    = 0;
    int          useful_words   = 0;
    int          idle_cycles    = 0;

    sorted_table_floor_ceil_search #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_floor_found (o_floor_found),
        .o_floor_value (o_floor_value),
        .o_ceil_found  (o_ceil_found),
        .o_ceil_value  (o_ceil_value)
    );

    always #2 i_clk = ~i_clk;

    // binary search over the mirror; one probe path gives both bounds
    function automatic t_bounds search_bounds(t_word target);
        int      lo;
        int      hi;
        int      mid;
        t_word   probe;
        t_bounds b;
        b.floor_found = 1'b0;
        b.floor_value = NOT_FOUND;
        b.ceil_found  = 1'b0;
        b.ceil_value  = NOT_FOUND;
        lo = 0;
        hi = mirror_count - 1;
        while (lo <= hi) begin
            mid   = lo + (hi - lo) / 2;
            probe = table_mirror[mid];
            if (probe == target) begin
                // exact hit ends the search with the target as both bounds
                b.floor_found = 1'b1;
                b.floor_value = target;
                b.ceil_found  = 1'b1;
                b.ceil_value  = target;
                return b;
            end
            if (probe > target) begin
                b.ceil_found = 1'b1;
                b.ceil_value = probe;
                hi = mid - 1;
            end else begin
                b.floor_found = 1'b1;
                b.floor_value = probe;
                lo = mid + 1;
            end
        end
        return b;
    endfunction

    // update the mirror for one accepted word
    task automatic track_word(t_op op, t_word value);
        case (op)
            OP_CLEAR: begin
                mirror_count = 0;
            end
            OP_APPEND: begin
                if (mirror_count < DEPTH) begin
                    table_mirror[mirror_count] = value;
                    mirror_count++;
                end
            end
            OP_QUERY: begin
                expected_bounds.push_back(search_bounds(value));
            end
            default: begin
            end
        endcase
    endtask

    // send one word, with random idle cycles ahead of it
    task automatic send_word(t_op op, t_word value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_word(op, value);
        if (op != OP_UNUSED) useful_words++;
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // query target near a stored entry, random, or at the word extremes
    function automatic t_word pick_target();
        int     pick;
        int     offset;
        longint t;
        pick = $urandom_range(9);
        if (mirror_count == 0 || pick >= 7) begin
            case ($urandom_range(3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                default: return t_word'($urandom);
            endcase
        end
        offset = int'($urandom_range(2)) - 1;
        t = longint'(table_mirror[$urandom_range(mirror_count - 1)]) + longint'(offset);
        return t_word'(t[31:0]);
    endfunction

    // append an ascending run; narrow steps keep long runs inside the word range
    task automatic append_sorted_run(int n, bit narrow);
        longint cur;
        longint step;
        case ($urandom_range(3))
            0: cur = longint'(WORD_MIN);
            1: cur = -longint'($urandom_range(1000));
            2: cur = longint'(t_word'($urandom)) / 2;
            default: cur = longint'(t_word'($urandom));
        endcase
        for (int i = 0; i < n; i++) begin
            if (narrow) begin
                step = longint'($urandom_range(8));
            end else begin
                case ($urandom_range(3))
                    0: step = 0;
                    1: step = longint'($urandom_range(3));
                    2: step = longint'($urandom_range(100000));
                    default: step = longint'($urandom) >> $urandom_range(31);
                endcase
            end
            if (i != 0) cur = cur + step;
            if (cur > longint'(WORD_MAX)) cur = longint'(WORD_MAX);
            send_word(OP_APPEND, t_word'(cur[31:0]));
        end
    endtask

    // extremes, empty table, exact hits, out-of-range targets, unused op
    task automatic test_directed_edges();
        send_word(OP_QUERY, 32'sd0);
        send_word(OP_APPEND, WORD_MIN);
        send_word(OP_APPEND, -32'sd5);
        send_word(OP_APPEND, 32'sd0);
        send_word(OP_APPEND, 32'sd0);
        send_word(OP_APPEND, 32'sd7);
        send_word(OP_APPEND, WORD_MAX);
        send_word(OP_QUERY, WORD_MIN);
        send_word(OP_QUERY, WORD_MAX);
        send_word(OP_QUERY, -32'sd6);
        send_word(OP_QUERY, 32'sd3);
        send_word(OP_QUERY, 32'sd7);
        send_word(OP_QUERY, 32'sd0);
        send_word(OP_QUERY, 32'sh7fff_fffe);
        send_word(OP_UNUSED, 32'shffff_ffff);
        send_word(OP_QUERY, 32'sd1);
        send_word(OP_CLEAR, 32'shffff_ffff);
        send_word(OP_QUERY, 32'sd7);
        send_word(OP_APPEND, 32'sd5);
        send_word(OP_QUERY, 32'sd4);
        send_word(OP_QUERY, 32'sd6);
        send_word(OP_QUERY, 32'sd5);
    endtask

    // fill the table, push one word past the end, search, then clear and reuse it
    task automatic test_full_table();
        send_word(OP_CLEAR, 32'sd0);
        append_sorted_run(DEPTH, 1'b1);
        send_word(OP_APPEND, WORD_MIN);
        send_word(OP_QUERY, table_mirror[0]);
        send_word(OP_QUERY, table_mirror[DEPTH - 1]);
        send_word(OP_QUERY, table_mirror[DEPTH / 2]);
        send_word(OP_QUERY, WORD_MIN);
        send_word(OP_QUERY, WORD_MAX);
        for (int i = 0; i < 8; i++) send_word(OP_QUERY, pick_target());
        send_word(OP_CLEAR, 32'sd0);
        send_word(OP_QUERY, table_mirror[3]);
        send_word(OP_APPEND, 32'sd3);
        send_word(OP_QUERY, 32'sd3);
    endtask

    // table out of order: the probe path alone decides the result
    task automatic test_unsorted_table();
        for (int r = 0; r < 2; r++) begin
            send_word(OP_CLEAR, t_word'($urandom));
            for (int i = 0; i < 2 + $urandom_range(14); i++) begin
                send_word(OP_APPEND, t_word'($urandom));
            end
            for (int i = 0; i < 8; i++) send_word(OP_QUERY, pick_target());
            send_word(OP_UNUSED, t_word'($urandom));
        end
    endtask

    // mostly well-formed sequences of clear, sorted appends and queries, some noise
    task automatic test_random_sequences(int word_target);
        int start;
        int n;
        start = useful_words;
        while (useful_words - start < word_target) begin
            if ($urandom_range(99) < 85) begin
                send_word(OP_CLEAR, t_word'($urandom));
                n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(16);
                append_sorted_run(n, 1'b0);
                for (int i = 0; i < 1 + $urandom_range(7); i++) begin
                    send_word(OP_QUERY, pick_target());
                end
            end else begin
                for (int i = 0; i < 1 + $urandom_range(5); i++) begin
                    send_word(t_op'($urandom_range(3)), t_word'($urandom));
                end
            end
        end
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker against the oldest expected bounds
    always @(posedge i_clk) begin
        t_bounds want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bounds.size() == 0) begin
                $error("result word with no query pending");
                error_count++;
            end else begin
                want = expected_bounds.pop_front();
                if (o_floor_found !== want.floor_found) begin
                    $error("floor_found expected %0d actual %0d",
                           want.floor_found, o_floor_found);
                    error_count++;
                end
                if (o_floor_value !== want.floor_value) begin
                    $error("floor_value expected %0d actual %0d",
                           want.floor_value, o_floor_value);
                    error_count++;
                end
                if (o_ceil_found !== want.ceil_found) begin
                    $error("ceil_found expected %0d actual %0d",
                           want.ceil_found, o_ceil_found);
                    error_count++;
                end
                if (o_ceil_value !== want.ceil_value) begin
                    $error("ceil_value expected %0d actual %0d",
                           want.ceil_value, o_ceil_value);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL sorted_table_floor_ceil_search");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed_edges();
        set_idling(14, 14);
        test_full_table();
        set_idling(64, 0);
        test_unsorted_table();

        set_idling(0, 0);
        test_random_sequences(15);
        set_idling(64, 0);
        test_random_sequences(15);
        set_idling(0, 64);
        test_random_sequences(15);
        set_idling(14, 14);
        test_random_sequences(15);

        // drain outstanding results
        i_valid <= 1'b0;
        while (expected_bounds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_bounds.size() != 0) begin
            $error("%0d query results never arrived", expected_bounds.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("PASS sorted_table_floor_ceil_search");
        end else begin
            $display("FAIL sorted_table_floor_ceil_search");
        end
        $finish;
    end

endmodule
